// File: src/llmc_pkg.sv
`default_nettype none

package llmc_pkg;

  // event kinds carried in the kind field
  typedef enum logic [1:0] {
    KIND_POWER_UP = 2'd0,
    KIND_TAP      = 2'd1,
    KIND_MICRO    = 2'd2,
    KIND_SAMPLE   = 2'd3
  } kind_e;

  // light modes as shown on the mode field
  typedef enum logic [2:0] {
    MODE_FIXED   = 3'd0,
    MODE_OPTIONS = 3'd1,
    MODE_CHECK   = 3'd2,
    MODE_BEACON  = 3'd3,
    MODE_STROBE  = 3'd4,
    MODE_CRIT    = 3'd5
  } mode_e;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_OPTION_BITS = 3'd0,
    REG_SAVED_LEVEL = 3'd1,
    REG_CRIT_THR    = 3'd2,
    REG_LOW_THR     = 3'd3,
    REG_QUARTER_THR = 3'd4,
    REG_HALF_THR    = 3'd5,
    REG_TQ_THR      = 3'd6
  } cfg_reg_e;

  // option bit positions
  localparam int unsigned OPT_LEVEL_MEM = 0;
  localparam int unsigned OPT_REVERSED  = 1;
  localparam int unsigned OPT_STROBE    = 2;

  // ramp anchor points, spread over the level count
  localparam logic [7:0] RAMP_PTS [4] = '{8'd5, 8'd35, 8'd118, 8'd255};

  localparam logic [7:0] DUTY_FLASH  = 8'd40;
  localparam logic [7:0] DUTY_BEACON = 8'd5;
  localparam logic [7:0] DUTY_TURBO  = 8'd255;

  localparam logic [3:0] TAPS_BEACON  = 4'd5;
  localparam logic [3:0] TAPS_CHECK   = 4'd6;
  localparam logic [3:0] TAPS_OPTIONS = 4'd10;
  localparam logic [3:0] TAPS_HOLD    = 4'd9;

  localparam logic [7:0] TICK_CLEAR  = 8'd4;
  localparam logic [6:0] CHECK_PHASE = 7'd14;

  localparam logic [2:0] OPT_RST   = 3'd0;
  localparam logic [2:0] SAVED_RST = 3'd0;
  localparam logic [7:0] CRIT_RST  = 8'd111;
  localparam logic [7:0] LOW_RST   = 8'd134;
  localparam logic [7:0] QTR_RST   = 8'd147;
  localparam logic [7:0] HALF_RST  = 8'd161;
  localparam logic [7:0] TQ_RST    = 8'd171;

  localparam logic [2:0] BLINKS_NONE = 3'd0;

endpackage

`default_nettype wire

// File: src/led_light_mode_controller_core.sv
`default_nettype none

// led light mode controller: takes one event word per cycle unless in_stall_o
// is high (cold power-up, short tap, timer microtick, battery sample) and
// answers each with exactly one result word (mode, pwm duty, output enable,
// level, battery check blinks, low battery flag, save request). every event
// is handled in a single pass of combinational logic that updates the mode
// state and loads the result register, so a new event is taken every cycle
// that the input is not stalled; the only limit is the one-deep result
// register, which holds a new word whenever the old one leaves in the same
// cycle. configuration writes are always ready and should only happen while
// no event is in flight. RAMP_LEN sets the number of brightness levels
// (2..64); the level output shows the low three bits of the level.
module led_light_mode_controller_core
  import llmc_pkg::*;
#(
  parameter int unsigned RAMP_LEN = 4
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // event word
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [1:0] kind_i,
  input  wire logic [7:0] voltage_i,
  // result word
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [2:0]      mode_o,
  output logic [7:0]      pwm_duty_o,
  output logic            output_on_o,
  output logic [2:0]      level_o,
  output logic [2:0]      blink_count_o,
  output logic            low_battery_o,
  output logic            save_request_o,
  // configuration writes
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic [2:0] cfg_index_i,
  input  wire logic [7:0] cfg_data_i
);

  // level register must hold RAMP_LEN and the 3-bit saved level
  localparam int unsigned LVL_W = ($clog2(RAMP_LEN + 1) > 3) ? $clog2(RAMP_LEN + 1) : 3;
  localparam int unsigned IDX_W = $clog2(RAMP_LEN);
  localparam int unsigned SPAN  = RAMP_LEN - 1;
  localparam logic [LVL_W-1:0] LVL_MAX = LVL_W'(RAMP_LEN);
  localparam logic [LVL_W-1:0] LVL_ONE = LVL_W'(1);

  // ramp table, worked out at elaboration
  logic [7:0] ramp_tbl [RAMP_LEN];

  for (genvar g = 0; g < RAMP_LEN; g++) begin : g_ramp
    localparam int X    = (g * 768) / SPAN;
    localparam int SEG  = X >> 8;
    localparam int FRAC = X & 255;
    localparam int SA   = (SEG >= 3) ? 3 : SEG;
    localparam int SB   = (SEG >= 2) ? 3 : SEG + 1;
    localparam int PA   = int'(RAMP_PTS[SA]);
    localparam int PB   = int'(RAMP_PTS[SB]);
    localparam int VAL  = (SEG >= 3) ? PB : PA + (((PB - PA) * FRAC) >> 8);
    assign ramp_tbl[g] = 8'(VAL);
  end

  // configuration registers
  logic [2:0] opt_q;
  logic [2:0] saved_q;
  logic [7:0] crit_q, low_q, qtr_q, half_q, tq_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      opt_q   <= OPT_RST;
      saved_q <= SAVED_RST;
      crit_q  <= CRIT_RST;
      low_q   <= LOW_RST;
      qtr_q   <= QTR_RST;
      half_q  <= HALF_RST;
      tq_q    <= TQ_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_OPTION_BITS: opt_q   <= cfg_data_i[2:0];
        REG_SAVED_LEVEL: saved_q <= cfg_data_i[2:0];
        REG_CRIT_THR:    crit_q  <= cfg_data_i;
        REG_LOW_THR:     low_q   <= cfg_data_i;
        REG_QUARTER_THR: qtr_q   <= cfg_data_i;
        REG_HALF_THR:    half_q  <= cfg_data_i;
        REG_TQ_THR:      tq_q    <= cfg_data_i;
        default: ;  // writes past the list are dropped
      endcase
    end
  end

  // handshake: the result register empties or is taken this cycle
  logic in_acc;
  assign in_stall_o = out_valid_o && out_stall_i;
  assign in_acc     = in_valid_i && !in_stall_o;

  // controller state
  mode_e            mode_q, mode_d;
  logic [LVL_W-1:0] level_q, level_d;
  logic [3:0]       tap_q, tap_d, tap_inc;
  logic [7:0]       micro_q, micro_d;
  logic [7:0]       tick_q, tick_d;
  logic             pend_q, pend_d;

  // per-event results
  logic [2:0]       blinks;
  logic             low_flag, save_flag;
  logic [7:0]       duty;
  logic             on_flag;
  logic [LVL_W-1:0] lvl_clamp;
  logic [LVL_W-1:0] ramp_pos;

  assign tap_inc = tap_q + 4'd1;

  always_comb begin
    mode_d    = mode_q;
    level_d   = level_q;
    tap_d     = tap_q;
    micro_d   = micro_q;
    tick_d    = tick_q;
    pend_d    = pend_q;
    blinks    = BLINKS_NONE;
    low_flag  = 1'b0;
    save_flag = 1'b0;

    case (kind_e'(kind_i))
      KIND_POWER_UP: begin
        mode_d  = opt_q[OPT_STROBE] ? MODE_STROBE : MODE_FIXED;
        tap_d   = '0;
        micro_d = '0;
        tick_d  = '0;
        pend_d  = 1'b0;
        if (opt_q[OPT_LEVEL_MEM] && (saved_q != 3'd0)) begin
          // saved level saturates at the top of the ramp
          level_d = (LVL_W'(saved_q) > LVL_MAX) ? LVL_MAX : LVL_W'(saved_q);
        end else begin
          level_d = LVL_ONE;
        end
      end
      KIND_TAP: begin
        micro_d = '0;
        tick_d  = '0;
        pend_d  = 1'b0;
        tap_d   = tap_inc;
        if (tap_inc == TAPS_CHECK) begin
          mode_d = MODE_CHECK;
        end else if (tap_inc == TAPS_BEACON) begin
          mode_d = MODE_BEACON;
        end else if (tap_inc == TAPS_OPTIONS) begin
          tap_d  = TAPS_HOLD;
          mode_d = MODE_OPTIONS;
        end else if (mode_q == MODE_FIXED) begin
          level_d   = (level_q == LVL_MAX) ? LVL_ONE : level_q + LVL_ONE;
          save_flag = opt_q[OPT_LEVEL_MEM];
        end else begin
          mode_d = MODE_FIXED;
        end
      end
      KIND_MICRO: begin
        // 256 microticks wrap into one tick
        micro_d = micro_q - 8'd1;
        if (micro_d == 8'd0) begin
          tick_d = tick_q + 8'd1;
          if (tick_d == TICK_CLEAR) begin
            tap_d = '0;
          end
          if (tick_d[6:0] == CHECK_PHASE) begin
            pend_d = 1'b1;
          end
        end
      end
      KIND_SAMPLE: begin
        // critical lockout ignores samples
        if (mode_q != MODE_CRIT) begin
          if (mode_q == MODE_CHECK) begin
            if (voltage_i >= tq_q) begin
              blinks = 3'd4;
            end else if (voltage_i >= half_q) begin
              blinks = 3'd3;
            end else if (voltage_i >= qtr_q) begin
              blinks = 3'd2;
            end else begin
              blinks = 3'd1;
            end
          end
          if (pend_q) begin
            if (voltage_i <= crit_q) begin
              mode_d = MODE_CRIT;
              blinks = BLINKS_NONE;
            end else if (voltage_i <= low_q) begin
              low_flag = 1'b1;
            end
            pend_d = 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  // duty from the new mode and level
  always_comb begin
    lvl_clamp = (level_d > LVL_MAX) ? LVL_MAX : level_d;
    ramp_pos  = opt_q[OPT_REVERSED] ? (LVL_MAX - lvl_clamp) : (lvl_clamp - LVL_ONE);
    case (mode_d)
      MODE_FIXED: begin
        duty    = (level_d == '0) ? 8'd0 : ramp_tbl[ramp_pos[IDX_W-1:0]];
        on_flag = (level_d != '0);
      end
      MODE_BEACON: begin
        duty    = DUTY_BEACON;
        on_flag = 1'b1;
      end
      MODE_STROBE: begin
        duty    = DUTY_TURBO;
        on_flag = 1'b1;
      end
      default: begin
        duty    = DUTY_FLASH;
        on_flag = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_FIXED;
      level_q <= LVL_ONE;
      tap_q   <= '0;
      micro_q <= '0;
      tick_q  <= '0;
      pend_q  <= 1'b0;
    end else if (in_acc) begin
      mode_q  <= mode_d;
      level_q <= level_d;
      tap_q   <= tap_d;
      micro_q <= micro_d;
      tick_q  <= tick_d;
      pend_q  <= pend_d;
    end
  end

  // result register
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      mode_o         <= mode_d;
      pwm_duty_o     <= duty;
      output_on_o    <= on_flag;
      level_o        <= level_d[2:0];
      blink_count_o  <= blinks;
      low_battery_o  <= low_flag;
      save_request_o <= save_flag;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// File: src/llmc_core_chk.sv
`default_nettype none

module llmc_core_chk
  import llmc_pkg::*;
(
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_stall_o,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic [2:0] mode_o,
  input wire logic [7:0] pwm_duty_o,
  input wire logic       output_on_o,
  input wire logic [2:0] blink_count_o
);

  // an accepted word shows a result the next cycle
  a_accept_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> out_valid_o)
    else $error("accepted word gave no result");

  // a stalled result holds
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(mode_o) && $stable(pwm_duty_o)))
    else $error("stalled result changed");

  // light only in fixed, beacon or strobe
  a_on_modes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && output_on_o) |->
      (mode_o == MODE_FIXED || mode_o == MODE_BEACON || mode_o == MODE_STROBE))
    else $error("output enabled in a dark mode");

  // blinks only come from battery check mode
  a_blinks_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && blink_count_o != BLINKS_NONE) |->
      (mode_o == MODE_CHECK && blink_count_o <= 3'd4))
    else $error("blinks outside battery check");

endmodule

bind led_light_mode_controller_core llmc_core_chk u_llmc_core_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .mode_o        (mode_o),
  .pwm_duty_o    (pwm_duty_o),
  .output_on_o   (output_on_o),
  .blink_count_o (blink_count_o)
);

`default_nettype wire

// File: dv/tb_led_light_mode_controller_core.sv
`default_nettype none

module tb_led_light_mode_controller_core;
  import llmc_pkg::*;

  // brightness levels of the instance under test
  localparam int unsigned LEVELS          = 4;
  // slowest correct run is about 1.9k events, taken several times over
  localparam int unsigned CYCLE_LIMIT     = 1_000_000;
  localparam int unsigned DRAIN_CYCLES    = 8;
  localparam int unsigned HOLD_CYCLES     = 120;
  // 4 ticks of 256 microticks after a boot reach the tap count clearing
  localparam int unsigned MICROS_TO_CLEAR = 1024;
  localparam int unsigned MIX_PHASES      = 6;
  localparam int unsigned MIX_WORDS       = 120;
  localparam int unsigned WATCH_ROUNDS    = 1;
  localparam int unsigned PRESSURE_WORDS  = 40;
  localparam int unsigned REPORT_LIMIT    = 10;

  localparam logic [2:0] OPT_MEM_MASK    = 3'(1 << OPT_LEVEL_MEM);
  localparam logic [2:0] OPT_REV_MASK    = 3'(1 << OPT_REVERSED);
  localparam logic [2:0] OPT_STROBE_MASK = 3'(1 << OPT_STROBE);
  localparam logic [2:0] OPT_ALL         = OPT_MEM_MASK | OPT_REV_MASK | OPT_STROBE_MASK;
  localparam logic [2:0] OPT_NONE        = 3'd0;
  localparam logic [2:0] SAVED_MAX       = 3'd7;
  localparam logic [7:0] THR_MIN         = 8'd0;
  localparam logic [7:0] THR_MAX         = 8'd255;

  // one result word as the block should present it
  typedef struct packed {
    mode_e      mode;
    logic [7:0] duty;
    logic       enabled;
    logic [2:0] level;
    logic [2:0] blinks;
    logic       low_bat;
    logic       save;
  } light_word_t;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  kind_e      kind_i;
  logic [7:0] voltage_i;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [2:0] mode_o;
  logic [7:0] pwm_duty_o;
  logic       output_on_o;
  logic [2:0] level_o;
  logic [2:0] blink_count_o;
  logic       low_battery_o;
  logic       save_request_o;
  logic       cfg_valid_i;
  logic       cfg_ready_o;
  cfg_reg_e   cfg_index_i;
  logic [7:0] cfg_data_i;

  // words predicted at acceptance, oldest first
  light_word_t pending_lights[$];

  // predicted light state
  mode_e       lt_mode;
  int unsigned lt_level;
  logic [3:0]  lt_taps;
  logic [7:0]  lt_micro;
  logic [7:0]  lt_tick;
  logic        lt_check;

  // predicted register contents
  logic [2:0] opt_bits;
  logic [2:0] saved_lvl;
  logic [7:0] crit_thr;
  logic [7:0] low_thr;
  logic [7:0] qtr_thr;
  logic [7:0] half_thr;
  logic [7:0] tq_thr;

  // idling controls shared by the sender, the stall driver and the tests
  logic tx_idle_on  = 1'b1;
  logic rx_idle_on  = 1'b1;
  logic hold_req    = 1'b0;
  logic hold_active = 1'b0;

  int unsigned n_errors;
  int unsigned n_words;
  int unsigned n_kind [4];
  int unsigned n_low;
  int unsigned n_lock;
  int unsigned n_backpressure;
  int unsigned cycle_cnt;

  led_light_mode_controller_core #(
    .RAMP_LEN(LEVELS)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .kind_i        (kind_i),
    .voltage_i     (voltage_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .mode_o        (mode_o),
    .pwm_duty_o    (pwm_duty_o),
    .output_on_o   (output_on_o),
    .level_o       (level_o),
    .blink_count_o (blink_count_o),
    .low_battery_o (low_battery_o),
    .save_request_o(save_request_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------
  // light state predictor
  // ---------------------------------------------------------------------

  task automatic reset_light_state();
    lt_mode   = MODE_FIXED;
    lt_level  = 1;
    lt_taps   = '0;
    lt_micro  = '0;
    lt_tick   = '0;
    lt_check  = 1'b0;
    opt_bits  = OPT_RST;
    saved_lvl = SAVED_RST;
    crit_thr  = CRIT_RST;
    low_thr   = LOW_RST;
    qtr_thr   = QTR_RST;
    half_thr  = HALF_RST;
    tq_thr    = TQ_RST;
  endtask

  // four anchor points spread linearly over the levels
  function automatic int unsigned ramp_duty(int unsigned idx);
    int unsigned span, x, seg, frac, a, b;
    span = (LEVELS > 1) ? LEVELS - 1 : 1;
    x    = (idx * 768) / span;
    seg  = x >> 8;
    frac = x & 255;
    a    = 0;
    b    = 0;
    case (seg)
      0: begin
        a = 5;
        b = 35;
      end
      1: begin
        a = 35;
        b = 118;
      end
      2: begin
        a = 118;
        b = 255;
      end
      default: return 255;
    endcase
    return a + (((b - a) * frac) >> 8);
  endfunction

  // apply one event to the predicted state and build the word it answers with
  function automatic light_word_t predict_light(kind_e k, logic [7:0] v);
    light_word_t w;
    int unsigned lv, duty;
    logic        en;
    w.blinks  = BLINKS_NONE;
    w.low_bat = 1'b0;
    w.save    = 1'b0;
    case (k)
      KIND_POWER_UP: begin
        lt_mode = opt_bits[OPT_STROBE] ? MODE_STROBE : MODE_FIXED;
        lt_taps = '0;
        if (opt_bits[OPT_LEVEL_MEM] && saved_lvl != 3'd0) begin
          // a remembered level beyond the ramp saturates
          lt_level = (saved_lvl > LEVELS) ? LEVELS : saved_lvl;
        end else begin
          lt_level = 1;
        end
        lt_micro = '0;
        lt_tick  = '0;
        lt_check = 1'b0;
      end
      KIND_TAP: begin
        lt_micro = '0;
        lt_tick  = '0;
        lt_check = 1'b0;
        lt_taps  = lt_taps + 4'd1;
        if (lt_taps == TAPS_CHECK) begin
          lt_mode = MODE_CHECK;
        end else if (lt_taps == TAPS_BEACON) begin
          lt_mode = MODE_BEACON;
        end else if (lt_taps == TAPS_OPTIONS) begin
          lt_taps = TAPS_HOLD;
          lt_mode = MODE_OPTIONS;
        end else if (lt_mode == MODE_FIXED) begin
          lt_level = (lt_level % LEVELS) + 1;
          w.save   = opt_bits[OPT_LEVEL_MEM];
        end else begin
          lt_mode = MODE_FIXED;
        end
      end
      KIND_MICRO: begin
        lt_micro = lt_micro - 8'd1;
        if (lt_micro == 8'd0) begin
          lt_tick = lt_tick + 8'd1;
          if (lt_tick == TICK_CLEAR) lt_taps = '0;
          if (lt_tick[6:0] == CHECK_PHASE) lt_check = 1'b1;
        end
      end
      KIND_SAMPLE: begin
        // samples are ignored during the critical lockout
        if (lt_mode != MODE_CRIT) begin
          if (lt_mode == MODE_CHECK) begin
            if (v >= tq_thr) w.blinks = 3'd4;
            else if (v >= half_thr) w.blinks = 3'd3;
            else if (v >= qtr_thr) w.blinks = 3'd2;
            else w.blinks = 3'd1;
          end
          if (lt_check) begin
            if (v <= crit_thr) begin
              lt_mode  = MODE_CRIT;
              w.blinks = BLINKS_NONE;
              n_lock++;
            end else if (v <= low_thr) begin
              w.low_bat = 1'b1;
              n_low++;
            end
            lt_check = 1'b0;
          end
        end
      end
      default: ;
    endcase

    case (lt_mode)
      MODE_FIXED: begin
        if (lt_level == 0) begin
          duty = 0;
        end else begin
          lv   = (lt_level > LEVELS) ? LEVELS : lt_level;
          duty = ramp_duty(opt_bits[OPT_REVERSED] ? LEVELS - lv : lv - 1);
        end
        en = (lt_level != 0);
      end
      MODE_BEACON: begin
        duty = DUTY_BEACON;
        en   = 1'b1;
      end
      MODE_STROBE: begin
        duty = DUTY_TURBO;
        en   = 1'b1;
      end
      default: begin
        duty = DUTY_FLASH;
        en   = 1'b0;
      end
    endcase

    w.mode    = lt_mode;
    w.duty    = 8'(duty);
    w.enabled = en;
    w.level   = 3'(lt_level);
    return w;
  endfunction

  // ---------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------

  function automatic kind_e pick_kind();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return KIND_POWER_UP;
    if (r < 45) return KIND_TAP;
    if (r < 75) return KIND_MICRO;
    return KIND_SAMPLE;
  endfunction

  // voltages aimed at the lockout band, the flicker band and the blink steps
  function automatic logic [7:0] pick_volt();
    int unsigned r;
    logic [7:0]  base;
    r = $urandom_range(0, 99);
    if (r < 25) return 8'($urandom_range(0, crit_thr));
    if (r < 45 && low_thr > crit_thr) return 8'($urandom_range(crit_thr + 1, low_thr));
    if (r < 65) begin
      case ($urandom_range(0, 2))
        0:       base = qtr_thr;
        1:       base = half_thr;
        default: base = tq_thr;
      endcase
      return 8'(base + $urandom_range(0, 2) - 1);
    end
    return 8'($urandom);
  endfunction

  // offer one event word, wait for it to be taken, then record its prediction
  task automatic send_event(kind_e k, logic [7:0] v);
    int unsigned gap, r;
    gap = 0;
    if (tx_idle_on) begin
      r = $urandom_range(0, 99);
      if (r >= 95) gap = $urandom_range(10, 30);
      else if (r >= 60) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i     <= k;
    voltage_i  <= v;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    @(negedge clk_i);
    pending_lights.push_back(predict_light(k, v));
    n_kind[k]++;
  endtask

  // stop offering and wait until every predicted word has come back
  task automatic settle_block();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending_lights.size() != 0);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [7:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    case (idx)
      REG_OPTION_BITS: opt_bits  = data[2:0];
      REG_SAVED_LEVEL: saved_lvl = data[2:0];
      REG_CRIT_THR:    crit_thr  = data;
      REG_LOW_THR:     low_thr   = data;
      REG_QUARTER_THR: qtr_thr   = data;
      REG_HALF_THR:    half_thr  = data;
      REG_TQ_THR:      tq_thr    = data;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // the narrow registers get random junk above their used bits
  task automatic load_settings(logic [2:0] opt, logic [2:0] saved, logic [7:0] crit,
                               logic [7:0] low, logic [7:0] qtr, logic [7:0] half,
                               logic [7:0] tq);
    write_reg(REG_OPTION_BITS, {5'($urandom), opt});
    write_reg(REG_SAVED_LEVEL, {5'($urandom), saved});
    write_reg(REG_CRIT_THR, crit);
    write_reg(REG_LOW_THR, low);
    write_reg(REG_QUARTER_THR, qtr);
    write_reg(REG_HALF_THR, half);
    write_reg(REG_TQ_THR, tq);
  endtask

  // ---------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------

  // tap ladder from reset: level wrap, beacon, battery check, options hold
  task automatic directed_events_test();
    send_event(KIND_SAMPLE, THR_MIN);
    send_event(KIND_SAMPLE, THR_MAX);
    send_event(KIND_MICRO, 8'($urandom));
    // taps one to four walk the levels and wrap back to one
    repeat (4) send_event(KIND_TAP, 8'($urandom));
    send_event(KIND_TAP, 8'($urandom));  // fifth: beacon
    send_event(KIND_TAP, 8'($urandom));  // sixth: battery check
    send_event(KIND_SAMPLE, THR_MAX);
    send_event(KIND_SAMPLE, THR_MIN);
    send_event(KIND_TAP, 8'($urandom));  // back to fixed, level kept
    repeat (2) send_event(KIND_TAP, 8'($urandom));
    send_event(KIND_TAP, 8'($urandom));  // tenth: options, count held
    send_event(KIND_TAP, 8'($urandom));  // still options
    send_event(KIND_POWER_UP, 8'($urandom));
  endtask

  // level memory with saturation, reversed ramp, start in strobe
  task automatic option_test();
    settle_block();
    load_settings(OPT_ALL, SAVED_MAX, CRIT_RST, LOW_RST, QTR_RST, HALF_RST, TQ_RST);
    send_event(KIND_POWER_UP, 8'($urandom));
    send_event(KIND_TAP, 8'($urandom));
    send_event(KIND_TAP, 8'($urandom));
    settle_block();
    write_reg(REG_OPTION_BITS, {5'd0, OPT_MEM_MASK});
    write_reg(REG_SAVED_LEVEL, 8'd3);
    send_event(KIND_POWER_UP, 8'($urandom));
    send_event(KIND_TAP, 8'($urandom));
    settle_block();
    write_reg(REG_OPTION_BITS, {5'd0, OPT_REV_MASK});
    send_event(KIND_POWER_UP, 8'($urandom));
    send_event(KIND_TAP, 8'($urandom));
    settle_block();
    load_settings(OPT_NONE, SAVED_RST, CRIT_RST, LOW_RST, QTR_RST, HALF_RST, TQ_RST);
  endtask

  // receiver holds off for a long stretch while words keep coming
  task automatic pressure_test();
    hold_req = 1'b1;
    while (!hold_active) @(negedge clk_i);
    tx_idle_on = 1'b0;
    repeat (PRESSURE_WORDS) send_event(pick_kind(), 8'($urandom));
    tx_idle_on = 1'b1;
  endtask

  // random event mix under several register settings, extremes included
  task automatic random_mix_test();
    for (int unsigned ph = 0; ph < MIX_PHASES; ph++) begin
      settle_block();
      case (ph)
        0: load_settings(OPT_RST, SAVED_RST, CRIT_RST, LOW_RST, QTR_RST, HALF_RST, TQ_RST);
        1: load_settings(OPT_ALL, SAVED_MAX, THR_MAX, THR_MAX, THR_MAX, THR_MAX, THR_MAX);
        2: load_settings(OPT_NONE, 3'd0, THR_MIN, THR_MIN, THR_MIN, THR_MIN, THR_MIN);
        default: load_settings(3'($urandom), 3'($urandom), 8'($urandom), 8'($urandom),
                               8'($urandom), 8'($urandom), 8'($urandom));
      endcase
      // some phases run with one side never idling
      tx_idle_on = (ph != 1);
      rx_idle_on = (ph != 2);
      repeat (MIX_WORDS) send_event(pick_kind(), pick_volt());
    end
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  // boot, taps, enough microticks to reach the fourth tick, then samples;
  // covers tick-four tap clearing, blinks in battery check mode and taps
  // counted afresh after the clearing
  task automatic battery_watch_test();
    int unsigned crit_v, low_v, qtr_v, half_v, tq_v, taps;
    for (int unsigned rd = 0; rd < WATCH_ROUNDS; rd++) begin
      settle_block();
      case (rd)
        0: begin
          crit_v = CRIT_RST;
          low_v  = LOW_RST;
          qtr_v  = QTR_RST;
          half_v = HALF_RST;
          tq_v   = TQ_RST;
        end
        1: begin
          crit_v = THR_MIN;
          low_v  = THR_MAX;
          qtr_v  = $urandom_range(0, 255);
          half_v = $urandom_range(0, 255);
          tq_v   = $urandom_range(0, 255);
        end
        2: begin
          crit_v = THR_MAX;
          low_v  = THR_MAX;
          qtr_v  = THR_MAX;
          half_v = THR_MAX;
          tq_v   = THR_MAX;
        end
        default: begin
          crit_v = $urandom_range(60, 180);
          low_v  = crit_v + $urandom_range(0, 40);
          qtr_v  = low_v + $urandom_range(0, 20);
          half_v = qtr_v + $urandom_range(0, 20);
          tq_v   = half_v + $urandom_range(0, 20);
          if (low_v > 255) low_v = 255;
          if (qtr_v > 255) qtr_v = 255;
          if (half_v > 255) half_v = 255;
          if (tq_v > 255) tq_v = 255;
        end
      endcase
      load_settings(3'($urandom), 3'($urandom), 8'(crit_v), 8'(low_v), 8'(qtr_v),
                    8'(half_v), 8'(tq_v));
      tx_idle_on = 1'($urandom_range(0, 1));
      rx_idle_on = 1'($urandom_range(0, 1));
      send_event(KIND_POWER_UP, 8'($urandom));
      taps = ($urandom_range(0, 2) == 0) ? 6 : $urandom_range(0, 7);
      repeat (taps) send_event(KIND_TAP, 8'($urandom));
      repeat (MICROS_TO_CLEAR) send_event(KIND_MICRO, 8'($urandom));
      repeat ($urandom_range(1, 3)) send_event(KIND_SAMPLE, pick_volt());
      send_event(KIND_TAP, 8'($urandom));
      send_event(KIND_SAMPLE, pick_volt());
      send_event(KIND_POWER_UP, 8'($urandom));
    end
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  // ---------------------------------------------------------------------
  // receiver stall driver: runs of stall or go, mostly short, a few long,
  // plus one long hold requested by the pressure test
  // ---------------------------------------------------------------------

  initial begin : stall_driver
    int unsigned run_len;
    logic        stall_val;
    forever begin
      if (hold_req) begin
        hold_active = 1'b1;
        stall_val   = 1'b1;
        run_len     = HOLD_CYCLES;
      end else if (!rx_idle_on) begin
        stall_val = 1'b0;
        run_len   = $urandom_range(1, 16);
      end else begin
        stall_val = ($urandom_range(0, 99) < 35);
        run_len   = ($urandom_range(0, 99) < 92) ? $urandom_range(1, 4)
                                                 : $urandom_range(12, 40);
      end
      out_stall_i <= stall_val;
      repeat (run_len) @(negedge clk_i);
      if (hold_active) begin
        hold_active = 1'b0;
        hold_req    = 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // result checker
  // ---------------------------------------------------------------------

  task automatic flag_mismatch(string field, logic [7:0] want, logic [7:0] got);
    n_errors++;
    if (n_errors <= REPORT_LIMIT) begin
      $display("mismatch in %s of result word %0d: expected %0d, got %0d",
               field, n_words, want, got);
    end
  endtask

  always @(posedge clk_i) begin : check_results
    light_word_t want;
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (pending_lights.size() == 0) begin
        n_errors++;
        if (n_errors <= REPORT_LIMIT) begin
          $display("result word with nothing expected: mode %0d duty %0d level %0d",
                   mode_o, pwm_duty_o, level_o);
        end
      end else begin
        want = pending_lights.pop_front();
        if (mode_o !== want.mode)
          flag_mismatch("mode", 8'(want.mode), 8'(mode_o));
        if (pwm_duty_o !== want.duty)
          flag_mismatch("pwm duty", want.duty, pwm_duty_o);
        if (output_on_o !== want.enabled)
          flag_mismatch("output on", 8'(want.enabled), 8'(output_on_o));
        if (level_o !== want.level)
          flag_mismatch("level", 8'(want.level), 8'(level_o));
        if (blink_count_o !== want.blinks)
          flag_mismatch("blinks", 8'(want.blinks), 8'(blink_count_o));
        if (low_battery_o !== want.low_bat)
          flag_mismatch("low battery", 8'(want.low_bat), 8'(low_battery_o));
        if (save_request_o !== want.save)
          flag_mismatch("save request", 8'(want.save), 8'(save_request_o));
        n_words++;
      end
    end
  end

  // watchdog and input back-pressure count
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (in_valid_i === 1'b1 && in_stall_o === 1'b1) n_backpressure++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still expected",
               cycle_cnt, pending_lights.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------

  initial begin
    in_valid_i  = 1'b0;
    kind_i      = KIND_POWER_UP;
    voltage_i   = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = REG_OPTION_BITS;
    cfg_data_i  = '0;
    rst_ni      = 1'b0;
    reset_light_state();
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    directed_events_test();
    option_test();
    pressure_test();
    random_mix_test();
    battery_watch_test();

    settle_block();
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    $display("events sent: %0d power-ups, %0d taps, %0d microticks, %0d samples",
             n_kind[KIND_POWER_UP], n_kind[KIND_TAP], n_kind[KIND_MICRO],
             n_kind[KIND_SAMPLE]);
    $display("%0d words checked, low-battery flags %0d, critical lockouts %0d",
             n_words, n_low, n_lock);
    $display("stalled input cycles %0d, errors %0d", n_backpressure, n_errors);
    if (n_errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire
